>>> src/mrwt_pkg.sv
// Package for the Miller-Rabin witness test block.
// Holds controller states and the controller/datapath command and status structs.
// No dependencies.
package mrwt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_POW,
        ST_CHECK,
        ST_SQUARE,
        ST_DONE
    } state_t;

    // multiplier operand select
    typedef enum logic [1:0] {
        MUL_RES_SQ,  // result * sq
        MUL_SQ_SQ,   // sq * sq
        MUL_X_X      // x * x (x held in result register)
    } mul_sel_t;

    typedef struct packed {
        logic     load;       // capture candidate and witness
        logic     split_step; // q >>= 1, s++
        logic     mul_start;  // start one modular multiply
        mul_sel_t mul_sel;
        logic     exp_shift;  // e >>= 1 when the square is started
        logic     s_dec;      // s-- (count remaining squarings down)
    } cmd_t;

    typedef struct packed {
        logic bad_input;
        logic q_odd;
        logic e_zero;
        logic e_lsb;
        logic mul_busy;
        logic mul_done;
        logic x_is_one;
        logic x_is_nm1;
        logic s_left;     // more squarings remain
    } status_t;

endpackage

>>> src/mrwt_datapath.sv
// Datapath: operand registers, exponent split, and a bit-serial modular multiplier
// (one shift-and-add step per cycle). Depends on mrwt_pkg.
module mrwt_datapath #(
    parameter int WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WIDTH-1:0]  n_in,
    input  logic [WIDTH-1:0]  a_in,
    input  mrwt_pkg::cmd_t    cmd,
    output mrwt_pkg::status_t status
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] n_reg, q_reg, res_reg, sq_reg;
    logic [CW-1:0]    s_reg;
    logic [WIDTH-1:0] mx_reg, my_reg, acc_reg;
    logic [CW-1:0]    bit_reg;
    logic             busy_reg, done_reg;
    logic [1:0]       dst_reg; // bit0: write res, bit1: write sq
    logic             bad_reg;

    logic [WIDTH-1:0] nm1, dbl, acc_next, mx_sel, my_sel;
    logic [WIDTH-1:0] gap1, gap2;
    logic             bad_next;

    assign nm1 = n_reg - WIDTH'(1);

    // modular add helpers: dbl = 2*acc mod n, then + x if bit set
    always_comb
    begin
        gap1 = n_reg - acc_reg;
        dbl  = (acc_reg >= gap1) ? acc_reg - gap1 : acc_reg + acc_reg;
        gap2 = n_reg - mx_reg;
        if (my_reg[WIDTH-1])
            acc_next = (dbl >= gap2) ? dbl - gap2 : dbl + mx_reg;
        else
            acc_next = dbl;
    end

    always_comb
    begin
        case (cmd.mul_sel)
            mrwt_pkg::MUL_RES_SQ:
            begin
                mx_sel = res_reg;
                my_sel = sq_reg;
            end
            mrwt_pkg::MUL_SQ_SQ:
            begin
                mx_sel = sq_reg;
                my_sel = sq_reg;
            end
            default:
            begin
                mx_sel = res_reg;
                my_sel = res_reg;
            end
        endcase
    end

    always_comb
    begin
        bad_next = (n_in < WIDTH'(5)) || !n_in[0] || (a_in < WIDTH'(2))
                   || (a_in > n_in - WIDTH'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.mul_start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg == CW'(0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= n_in;
            sq_reg  <= a_in;
            res_reg <= WIDTH'(1);
            q_reg   <= n_in - WIDTH'(1);
            s_reg   <= '0;
            bad_reg <= bad_next;
        end
        if (cmd.split_step)
        begin
            q_reg <= q_reg >> 1;
            s_reg <= s_reg + CW'(1);
        end
        if (cmd.exp_shift)
            q_reg <= q_reg >> 1;
        if (cmd.s_dec)
            s_reg <= s_reg - CW'(1);
        if (cmd.mul_start)
        begin
            mx_reg  <= mx_sel;
            my_reg  <= my_sel;
            acc_reg <= '0;
            bit_reg <= CW'(WIDTH - 1);
            dst_reg <= (cmd.mul_sel == mrwt_pkg::MUL_SQ_SQ) ? 2'b10 : 2'b01;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            my_reg  <= my_reg << 1;
            bit_reg <= bit_reg - CW'(1);
            if (bit_reg == CW'(0))
            begin
                if (dst_reg[0]) res_reg <= acc_next;
                if (dst_reg[1]) sq_reg  <= acc_next;
            end
        end
    end

    always_comb
    begin
        status.bad_input = bad_reg;
        status.q_odd     = q_reg[0];
        status.e_zero    = (q_reg == '0);
        status.e_lsb     = q_reg[0];
        status.mul_busy  = busy_reg;
        status.mul_done  = done_reg;
        status.x_is_one  = (res_reg == WIDTH'(1));
        status.x_is_nm1  = (res_reg == nm1);
        status.s_left    = (s_reg > CW'(1));
    end
endmodule

>>> src/mrwt_ctrl.sv
// Controller state machine: sequences split, square-and-multiply and squaring loop.
// Depends on mrwt_pkg.
module mrwt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  mrwt_pkg::status_t status,
    output mrwt_pkg::cmd_t    cmd,
    output logic              idle,
    output logic              res_valid,
    output logic              res_prime,
    output logic              res_error
);
    mrwt_pkg::state_t state_reg, state_next;
    logic prime_reg, prime_next;
    logic wait_reg, wait_next;   // multiply in flight
    logic sqpend_reg, sqpend_next; // pow: square still owed this bit

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mrwt_pkg::ST_IDLE;
            prime_reg  <= 1'b0;
            wait_reg   <= 1'b0;
            sqpend_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prime_reg  <= prime_next;
            wait_reg   <= wait_next;
            sqpend_reg <= sqpend_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        prime_next  = prime_reg;
        wait_next   = wait_reg;
        sqpend_next = sqpend_reg;
        cmd         = '0;
        cmd.mul_sel = mrwt_pkg::MUL_RES_SQ;
        case (state_reg)
            mrwt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    prime_next = 1'b0;
                    state_next = mrwt_pkg::ST_SPLIT;
                end
            end
            mrwt_pkg::ST_SPLIT:
            begin
                if (status.bad_input)
                    state_next = mrwt_pkg::ST_DONE;
                else if (!status.q_odd)
                    cmd.split_step = 1'b1;
                else
                begin
                    wait_next   = 1'b0;
                    sqpend_next = 1'b0;
                    state_next  = mrwt_pkg::ST_POW;
                end
            end
            mrwt_pkg::ST_POW:
            begin
                if (wait_reg)
                begin
                    if (status.mul_done)
                        wait_next = 1'b0;
                end
                else if (sqpend_reg)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = mrwt_pkg::MUL_SQ_SQ;
                    cmd.exp_shift = 1'b1;
                    sqpend_next   = 1'b0;
                    wait_next     = 1'b1;
                end
                else if (status.e_zero)
                    state_next = mrwt_pkg::ST_CHECK;
                else
                begin
                    sqpend_next = 1'b1;
                    if (status.e_lsb)
                    begin
                        cmd.mul_start = 1'b1;
                        wait_next     = 1'b1;
                    end
                end
            end
            mrwt_pkg::ST_CHECK:
            begin
                if (status.x_is_one || status.x_is_nm1)
                begin
                    prime_next = 1'b1;
                    state_next = mrwt_pkg::ST_DONE;
                end
                else if (status.s_left)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = mrwt_pkg::MUL_X_X;
                    cmd.s_dec     = 1'b1;
                    wait_next     = 1'b1;
                    state_next    = mrwt_pkg::ST_SQUARE;
                end
                else
                    state_next = mrwt_pkg::ST_DONE;
            end
            mrwt_pkg::ST_SQUARE:
            begin
                if (wait_reg)
                begin
                    if (status.mul_done)
                        wait_next = 1'b0;
                end
                else if (status.x_is_nm1)
                begin
                    prime_next = 1'b1;
                    state_next = mrwt_pkg::ST_DONE;
                end
                else if (status.x_is_one || !status.s_left)
                    state_next = mrwt_pkg::ST_DONE;
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = mrwt_pkg::MUL_X_X;
                    cmd.s_dec     = 1'b1;
                    wait_next     = 1'b1;
                end
            end
            mrwt_pkg::ST_DONE:
            begin
                if (out_fire)
                    state_next = mrwt_pkg::ST_IDLE;
            end
            default:
                state_next = mrwt_pkg::ST_IDLE;
        endcase
    end

    assign idle      = (state_reg == mrwt_pkg::ST_IDLE);
    assign res_valid = (state_reg == mrwt_pkg::ST_DONE);
    assign res_prime = prime_reg;
    assign res_error = status.bad_input;
endmodule

>>> src/miller_rabin_witness_test.sv
// Top level of the Miller-Rabin witness test: one round per input transfer.
// Instantiates mrwt_ctrl and mrwt_datapath; uses mrwt_pkg.
//
// Channel | Dir | Handshake              | Payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata[31:0] candidate, [63:32] witness
// m_axis  | out | m_axis_tvalid/tready   | tdata[0] probable_prime, [1] input_error
//
// One item at a time. Each modular multiply is a start, WIDTH shift-and-add steps, then
// done. With n-1 = 2^s*q a test runs at most 2*(WIDTH-s)+s-1 multiplies. On bad input
// the controller goes from ST_SPLIT straight to ST_DONE and starts no multiply.
// Reset clears the controller; the datapath holds no control state across items.
// A stalled result holds m_axis_tvalid; no new input is taken until it transfers.
module miller_rabin_witness_test #(
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] candidate, [63:32] witness
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [0] probable_prime, [1] input_error, rest 0
);
    mrwt_pkg::cmd_t    cmd;
    mrwt_pkg::status_t status;
    logic idle, res_valid, res_prime, res_error;
    logic in_fire, out_fire;
    logic [WIDTH-1:0] n_in, a_in;

    // candidate and witness are taken modulo 2^WIDTH
    always_comb
    begin
        n_in = WIDTH'({32'b0, s_axis_tdata[31:0]});
        a_in = WIDTH'({32'b0, s_axis_tdata[63:32]});
    end

    assign s_axis_tready = idle;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {6'b0, res_error, res_prime && !res_error};

    mrwt_datapath #(.WIDTH(WIDTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .n_in   (n_in),
        .a_in   (a_in),
        .cmd    (cmd),
        .status (status)
    );

    mrwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .status    (status),
        .cmd       (cmd),
        .idle      (idle),
        .res_valid (res_valid),
        .res_prime (res_prime),
        .res_error (res_error)
    );

    // intake and result delivery never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while result pending");

    // an input error never reports probable prime
    a_err_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
        else $error("error with prime flag");

    // a multiply is never started while one is running
    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !status.mul_busy)
        else $error("multiply restart while busy");
endmodule

>>> tb/miller_rabin_witness_test_tb.sv
// Testbench for miller_rabin_witness_test: streams candidate/witness pairs and checks
// each verdict against a behavioral Miller-Rabin predictor with random flow control.
// Depends on src/miller_rabin_witness_test.sv (and mrwt_pkg through it).
`timescale 1ns / 100ps

module miller_rabin_witness_test_tb;

    typedef struct packed {
        logic [31:0] witness;
        logic [31:0] candidate;
    } mr_item_t;

    typedef struct packed {
        logic input_error;
        logic probable_prime;
    } mr_verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] candidate, [63:32] witness
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] probable_prime, [1] input_error

    mr_item_t    pending_items[$];
    mr_verdict_t verdicts_due[$];
    int          mismatch_count = 0;
    int          verdict_count = 0;
    int          prime_count = 0;
    int          error_count = 0;
    bit          hold_request;      // stimulus asks for the long receiver stall
    bit          hold_active;       // long receiver stall in progress
    int          send_gap;
    int          recv_gap;

    miller_rabin_witness_test #(.WIDTH(32)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // (x + y) mod n with x, y < n, never wider than 32 bits
    function automatic logic [31:0] addmod(logic [31:0] x, logic [31:0] y, logic [31:0] n);
        logic [31:0] gap;
        gap = n - y;
        return (x >= gap) ? x - gap : x + y;
    endfunction

    function automatic logic [31:0] mulmod(logic [31:0] x, logic [31:0] y, logic [31:0] n);
        logic [31:0] acc;
        acc = '0;
        for (int b = 31; b >= 0; b--)
        begin
            acc = addmod(acc, acc, n);
            if (y[b])
                acc = addmod(acc, x, n);
        end
        return acc;
    endfunction

    function automatic logic [31:0] powmod(logic [31:0] base, logic [31:0] e, logic [31:0] n);
        logic [31:0] r;
        logic [31:0] sq;
        r  = 32'd1;
        sq = base;
        while (e != 0)
        begin
            if (e[0])
                r = mulmod(r, sq, n);
            sq = mulmod(sq, sq, n);
            e  = e >> 1;
        end
        return r;
    endfunction

    // one witness round: verdict for candidate n and base a
    function automatic mr_verdict_t witness_verdict(mr_item_t it);
        mr_verdict_t v;
        logic [31:0] n;
        logic [31:0] a;
        logic [31:0] q;
        logic [31:0] x;
        int          s;
        n = it.candidate;
        a = it.witness;
        v = '0;
        if (n < 5 || !n[0] || a < 2 || a > n - 2)
        begin
            v.input_error = 1'b1;
            return v;
        end
        q = n - 1;
        s = 0;
        while (!q[0])
        begin
            q = q >> 1;
            s++;
        end
        x = powmod(a, q, n);
        if (x == 1 || x == n - 1)
        begin
            v.probable_prime = 1'b1;
        end
        else
        begin
            // squaring to 1 before n-1 ends it early: composite
            for (int r = 1; r < s; r++)
            begin
                x = mulmod(x, x, n);
                if (x == n - 1)
                begin
                    v.probable_prime = 1'b1;
                    break;
                end
                if (x == 1)
                    break;
            end
        end
        return v;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] odd_rand(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] v;
        v = $urandom_range(hi, lo);
        return v | 32'd1;
    endfunction

    // small primes and a few known hard composites (Carmichael and strong pseudoprimes)
    localparam logic [31:0] SPECIAL_N [12] = '{
        32'd5, 32'd7, 32'd97, 32'd561, 32'd1105, 32'd2047, 32'd3277, 32'd65537,
        32'd25326001, 32'd3215031751, 32'd4294967291, 32'd4294967279
    };

    task automatic add_item(logic [31:0] n, logic [31:0] a);
        mr_item_t it;
        it.candidate = n;
        it.witness   = a;
        pending_items = {pending_items, it};
    endtask

    task automatic add_good_item(logic [31:0] n);
        add_item(n, $urandom_range(n - 2, 2));
    endtask

    // driver: offers queued items, random gaps between transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
        begin
            // hold the current item
        end
        else if (send_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= send_gap - 1;
        end
        else if (pending_items.size() > 0)
        begin
            if (s_axis_tvalid)
                send_gap <= pick_gap();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_items.pop_front();
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // expectations come from the accepted input transfer
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            verdicts_due = {verdicts_due, witness_verdict(mr_item_t'(s_axis_tdata))};
    end

    // long receiver stall, counted here once the stimulus asks for it
    initial
    begin
        hold_active = 1'b0;
        wait (hold_request);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (6000) @(posedge clk);
        hold_active <= 1'b0;
    end

    // monitor: random tready, checks every output transfer in order
    always @(posedge clk or negedge rst_n)
    begin
        mr_verdict_t want;
        mr_verdict_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = mr_verdict_t'(m_axis_tdata[1:0]);
                verdict_count++;
                if (verdicts_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected verdict %b, nothing pending", got);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    prime_count += want.probable_prime;
                    error_count += want.input_error;
                    if (got.probable_prime !== want.probable_prime
                        || got.input_error !== want.input_error
                        || m_axis_tdata[7:2] !== '0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("verdict %0d: want prime=%b err=%b, got tdata=%b",
                                     verdict_count, want.probable_prime,
                                     want.input_error, m_axis_tdata);
                    end
                end
            end
            if (hold_active)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap      <= recv_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid)
                    recv_gap <= pick_gap();
            end
        end
    end

    initial
    begin
        logic [31:0] n;
        rst_n        = 1'b0;
        hold_request = 1'b0;

        // directed: bad inputs, witness extremes, primes and pseudoprimes
        add_item(32'd0, 32'd2);
        add_item(32'd3, 32'd2);
        add_item(32'd4, 32'd2);
        add_item(32'd1000, 32'd3);
        add_item(32'hFFFF_FFFE, 32'd3);
        add_item(32'd101, 32'd1);
        add_item(32'd101, 32'd0);
        add_item(32'd101, 32'd100);
        add_item(32'd101, 32'hFFFF_FFFF);
        add_item(32'd5, 32'd2);
        add_item(32'd5, 32'd3);
        add_item(32'hFFFF_FFFF, 32'd2);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFD);
        add_item(32'd2047, 32'd2);
        add_item(32'd561, 32'd2);
        add_item(32'd25326001, 32'd2);
        add_item(32'd4294967291, 32'd4294967289);
        add_item(32'd65537, 32'd3);
        add_item(32'd9, 32'd8);
        add_item(32'hAAAA_AAAB, 32'h5555_5555);
        add_item(32'h5555_5555, 32'h2AAA_AAAA);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 300; i++)
        begin
            // long receiver stall once, with the sender busy
            if (i == 150)
            begin
                wait (pending_items.size() == 0);
                @(posedge clk);
                hold_request = 1'b1;
                for (int k = 0; k < 6; k++)
                    add_good_item(odd_rand(5, 32'hFFFF_FFFF) | 32'd1);
            end
            case ($urandom_range(0, 9))
                0:       add_item($urandom, $urandom);
                1:       add_item($urandom_range(8, 0), $urandom_range(10, 0));
                2:       add_good_item(SPECIAL_N[$urandom_range(11, 0)]);
                3:       add_good_item(odd_rand(5, 1000));
                4:
                begin
                    n = odd_rand(5, 32'hFFFF_FFFF);
                    n = (n < 5) ? 32'd5 : n;
                    add_item(n, $urandom_range(1, 0) ? 32'd1 : n - 1);
                end
                default:
                begin
                    n = odd_rand(7, 32'hFFFF_FFFF);
                    add_good_item(n);
                end
            endcase
            if (pending_items.size() > 8)
                wait (pending_items.size() < 4);
        end

        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (verdicts_due.size() == 0);
        repeat (3000) @(posedge clk);
        $display("%0d verdicts checked: %0d probable prime, %0d bad input, %0d mismatches",
                 verdict_count, prime_count, error_count, mismatch_count);
        $display("covered primes, Carmichael numbers, strong pseudoprimes and range limits");
        if (mismatch_count == 0 && verdicts_due.size() == 0)
            $display("miller_rabin_witness_test_tb: done, clean");
        else
            $display("miller_rabin_witness_test_tb: done, errors");
        $finish;
    end

    // watchdog: time for ~330 items plus stalls, taken several times over
    initial
    begin
        #40_000_000;
        $display("miller_rabin_witness_test_tb: done, errors");
        $finish;
    end

endmodule
